### rtl/core/rtd_code_to_temperature_core_defines.svh
// Assertion macros shared by the RTD code to temperature core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RTD_CODE_TO_TEMPERATURE_CORE_DEFINES_SVH
`define RTD_CODE_TO_TEMPERATURE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rtdc_pkg.sv
// Shared types and constants for the RTD code to temperature core.
// No dependencies; used by every other file of the core but the defines header.
package rtdc_pkg;

  // Field and datapath widths.
  localparam int WORD_W      = 16;
  localparam int FS_W        = 8;
  localparam int REF_W       = 16;
  localparam int NOM_W       = 14;
  localparam int CODE_W      = 15;
  localparam int CODE_FRAC_W = 15;
  localparam int SCALED_W    = 31;
  localparam int SCALED5_W   = SCALED_W + 3;
  localparam int RES_W       = 24;
  localparam int RES_SH      = SCALED_W - RES_W;
  localparam int STATUS_W    = 3;
  localparam int TEMP_W      = 19;
  localparam int DIFF_W      = 33;
  localparam int NUM_W       = 43;
  localparam int DEN_W       = 23;
  localparam int DVD_W       = 40;
  localparam int QUO_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [REF_W-1:0] REF_RESET = REF_W'(430);
  localparam logic [NOM_W-1:0] NOM_RESET = NOM_W'(100);

  // Fault status bit positions.
  localparam int FS_BIT_REF_LOW    = 5;
  localparam int FS_BIT_REF_HIGH   = 4;
  localparam int FS_BIT_PROBE_OPEN = 3;
  localparam int FS_BIT_OVUV       = 2;

  // T*256 = (R*32768 - R0*32768) * 625 / (308 * R0), limits at -40 and 200 degrees.
  localparam logic signed [NUM_W-1:0] TEMP_NUM_K = NUM_W'(625);
  localparam logic [DEN_W-1:0]        TEMP_DEN_K = DEN_W'(308);
  localparam logic [NUM_W-1:0]        TEMP_LO_K  = NUM_W'(3153920);
  localparam logic [NUM_W-1:0]        TEMP_HI_K  = NUM_W'(15769600);

  localparam logic signed [TEMP_W-1:0] TEMP_INVALID = TEMP_W'(-255744);
  localparam logic signed [TEMP_W-1:0] TEMP_MIN_Q8  = TEMP_W'(-10240);
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_Q8  = TEMP_W'(51200);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_PROBE_OPEN = 3'd1,
    ST_DEVICE     = 3'd2,
    ST_RES_RANGE  = 3'd3,
    ST_TEMP_RANGE = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_RES = 1'b0,
    REG_RTD_NOM = 1'b1
  } cfg_reg_t;

  // Result fields that ride alongside the divider.
  typedef struct packed {
    status_t          status;
    logic             clr;
    logic [RES_W-1:0] res_q8;
    logic             neg;
  } rtdc_meta_t;

  typedef struct packed {
    rtdc_meta_t       meta;
    logic [DVD_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } rtdc_div_req_t;

  typedef struct packed {
    rtdc_meta_t       meta;
    logic [QUO_W-1:0] quotient;
  } rtdc_div_rsp_t;

endpackage

### rtl/core/rtdc_ifs.sv
// Valid/ready channel interfaces for the RTD code to temperature core.
// Depends on rtdc_pkg for field widths.
interface rtdc_in_if;
  logic                          valid;
  logic                          ready;
  logic [rtdc_pkg::WORD_W-1:0]   rtd_word;
  logic [rtdc_pkg::FS_W-1:0]     fault_byte;

  modport source (output valid, rtd_word, fault_byte, input ready);
  modport sink   (input valid, rtd_word, fault_byte, output ready);
endinterface

interface rtdc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rtdc_pkg::STATUS_W-1:0] status;
  logic                          fault_clear_request;
  logic [rtdc_pkg::RES_W-1:0]    resistance_q8;
  logic [rtdc_pkg::TEMP_W-1:0]   temperature_q8;

  modport source (output valid, status, fault_clear_request, resistance_q8,
                  temperature_q8, input ready);
  modport sink   (input valid, status, fault_clear_request, resistance_q8,
                  temperature_q8, output ready);
endinterface

### rtl/core/rtd_code_to_temperature_core.sv
// Top level of the RTD code to temperature core: configuration registers,
// front end, divider and output register. Depends on rtdc_pkg, rtdc_ifs,
// rtdc_front, rtdc_div and the core defines header.
//
// Each request carries a raw RTD word and a fault status byte and yields one
// result: status, fault clear request, resistance in Q8 ohms and temperature
// in signed Q8 degrees C (-999 when invalid). The core accepts one request
// per clock and returns results in order through four front-end stages
// (scaling multiply, resistance window, constant products, temperature
// window), sixteen stages of the restoring divider, one bit of the quotient
// in each, and the output register. Every stage holds its own valid bit, so
// when the result side stalls the pipeline keeps filling its empty stages
// and stops taking requests only once all are full. Configuration writes act
// at once; the user must make them while no request is in flight, unchecked.

`include "rtd_code_to_temperature_core_defines.svh"

module rtd_code_to_temperature_core (
  input  logic                             clk,
  input  logic                             rst_n,
  rtdc_in_if.sink                          in_ch,
  rtdc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [rtdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rtdc_pkg::*;

  logic [REF_W-1:0]         ref_r;
  logic [NOM_W-1:0]         nom_r;

  logic                     fe_valid;
  logic                     fe_ready;
  rtdc_div_req_t            fe_req;
  logic                     dv_valid;
  logic                     dv_ready;
  rtdc_div_rsp_t            dv_rsp;

  logic                     o_v_r;
  status_t                  o_status_r;
  logic                     o_clr_r;
  logic [RES_W-1:0]         o_res_q8_r;
  logic signed [TEMP_W-1:0] o_temp_r;
  logic signed [TEMP_W-1:0] quo_ext;
  logic signed [TEMP_W-1:0] o_temp_nxt;
  logic                     en_o;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
      nom_r <= NOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_RES: ref_r <= cfg_wdata[REF_W-1:0];
        REG_RTD_NOM: nom_r <= cfg_wdata[NOM_W-1:0];
        default: ;
      endcase
    end
  end

  rtdc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .ref_ohms (ref_r),
    .nom_ohms (nom_r),
    .dn_valid (fe_valid),
    .dn_ready (fe_ready),
    .dn_req   (fe_req)
  );

  rtdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fe_valid),
    .up_ready (fe_ready),
    .up_req   (fe_req),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn_rsp   (dv_rsp)
  );

  // Output register: apply the sign, or the invalid marker when not ok.
  assign en_o     = !o_v_r || out_ch.ready;
  assign dv_ready = en_o;

  always_comb begin
    quo_ext    = $signed(TEMP_W'(dv_rsp.quotient));
    o_temp_nxt = dv_rsp.meta.neg ? -quo_ext : quo_ext;
    if (dv_rsp.meta.status != ST_OK) begin
      o_temp_nxt = TEMP_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en_o) begin
      o_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && dv_valid) begin
      o_status_r <= dv_rsp.meta.status;
      o_clr_r    <= dv_rsp.meta.clr;
      o_res_q8_r <= dv_rsp.meta.res_q8;
      o_temp_r   <= o_temp_nxt;
    end
  end

  assign out_ch.valid               = o_v_r;
  assign out_ch.status              = o_status_r;
  assign out_ch.fault_clear_request = o_clr_r;
  assign out_ch.resistance_q8       = o_res_q8_r;
  assign out_ch.temperature_q8      = o_temp_r;

  // Requests are refused only while a result is held at the output.
  `RTDC_ASSERT_IMP(a_refuse_only_on_hold, clk, rst_n, !in_ch.ready, out_ch.valid && !out_ch.ready, "input refused without output backpressure")
  `RTDC_ASSERT_NXT(a_refuse_keeps_result, clk, rst_n, !in_ch.ready, out_ch.valid, "output lost while input was refused")
  // Clear requests come only with a device fault and no resistance.
  `RTDC_ASSERT_IMP(a_clear_on_device_fault, clk, rst_n, out_ch.valid && out_ch.fault_clear_request, out_ch.status == ST_DEVICE && out_ch.resistance_q8 == '0, "fault clear request without device fault")
  // Any non-ok result carries the invalid temperature marker.
  `RTDC_ASSERT_IMP(a_invalid_marker, clk, rst_n, out_ch.valid && out_ch.status != ST_OK, $signed(out_ch.temperature_q8) == TEMP_INVALID, "bad status without invalid temperature")
  // An ok result lies inside the accepted temperature window.
  `RTDC_ASSERT_IMP(a_ok_in_window, clk, rst_n, out_ch.valid && out_ch.status == ST_OK, $signed(out_ch.temperature_q8) >= TEMP_MIN_Q8 && $signed(out_ch.temperature_q8) <= TEMP_MAX_Q8, "ok temperature outside window")

endmodule

### rtl/core/rtdc_front.sv
// Front end of the converter: fault decode, code scaling, range checks and
// divider operand preparation in four register stages. Depends on rtdc_pkg, rtdc_ifs.
module rtdc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  rtdc_in_if.sink                     in_ch,
  input  logic [rtdc_pkg::REF_W-1:0]  ref_ohms,
  input  logic [rtdc_pkg::NOM_W-1:0]  nom_ohms,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output rtdc_pkg::rtdc_div_req_t     dn_req
);
  import rtdc_pkg::*;

  logic en_a, en_b, en_c, en_d;

  // Stage A signals.
  logic                a_v_r;
  logic                a_fault_r;
  status_t             a_status_r;
  logic                a_clr_r;
  logic [SCALED_W-1:0] a_scaled_r;
  logic [CODE_W-1:0]   in_code;
  status_t             a_status_nxt;
  logic                a_clr_nxt;
  logic [SCALED_W-1:0] a_scaled_nxt;

  // Stage B signals.
  logic                     b_v_r;
  status_t                  b_status_r;
  logic                     b_clr_r;
  logic [RES_W-1:0]         b_res_q8_r;
  logic signed [DIFF_W-1:0] b_diff_r;
  logic [SCALED5_W-1:0]     scaled5;
  logic [SCALED5_W-1:0]     nom_lo;
  logic [SCALED_W-1:0]      nom_hi;
  logic                     res_bad;
  status_t                  b_status_nxt;
  logic [RES_W-1:0]         b_res_q8_nxt;
  logic signed [DIFF_W-1:0] b_diff_nxt;

  // Stage C signals.
  logic                    c_v_r;
  status_t                 c_status_r;
  logic                    c_clr_r;
  logic [RES_W-1:0]        c_res_q8_r;
  logic signed [NUM_W-1:0] c_num_r;
  logic [DEN_W-1:0]        c_den_r;
  logic [NUM_W-1:0]        c_lo_r;
  logic [NUM_W-1:0]        c_hi_r;

  // Stage D signals.
  logic             d_v_r;
  rtdc_div_req_t    d_req_r;
  logic             temp_bad;
  status_t          d_status_nxt;
  logic [NUM_W-1:0] num_abs;
  rtdc_div_req_t    d_req_nxt;

  // Each stage moves when it is empty or its successor moves.
  assign en_d        = !d_v_r || dn_ready;
  assign en_c        = !c_v_r || en_d;
  assign en_b        = !b_v_r || en_c;
  assign en_a        = !a_v_r || en_b;
  assign in_ch.ready = en_a;

  // Stage A: scale the code by the reference resistor and decode faults.
  assign in_code = in_ch.rtd_word[WORD_W-1:1];

  always_comb begin
    a_scaled_nxt = SCALED_W'(in_code) * SCALED_W'(ref_ohms);
    a_clr_nxt    = 1'b0;
    priority if (in_ch.fault_byte[FS_BIT_PROBE_OPEN]) begin
      a_status_nxt = ST_PROBE_OPEN;
    end else if (in_ch.fault_byte[FS_BIT_REF_LOW] || in_ch.fault_byte[FS_BIT_REF_HIGH] ||
                 in_ch.fault_byte[FS_BIT_OVUV]) begin
      a_status_nxt = ST_DEVICE;
    end else begin
      a_status_nxt = ST_DEVICE;
      a_clr_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en_a) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_ch.valid) begin
      a_fault_r  <= in_ch.rtd_word[0];
      a_status_r <= a_status_nxt;
      a_clr_r    <= a_clr_nxt;
      a_scaled_r <= a_scaled_nxt;
    end
  end

  // Stage B: resistance window 0.6..2.0 times nominal, on the exact scaled value.
  always_comb begin
    scaled5      = (SCALED5_W'(a_scaled_r) << 2) + SCALED5_W'(a_scaled_r);
    nom_lo       = (SCALED5_W'(nom_ohms) << (CODE_FRAC_W + 1)) +
                   (SCALED5_W'(nom_ohms) << CODE_FRAC_W);
    nom_hi       = SCALED_W'(nom_ohms) << (CODE_FRAC_W + 1);
    res_bad      = (scaled5 < nom_lo) || (a_scaled_r > nom_hi);
    b_diff_nxt   = $signed(DIFF_W'(a_scaled_r)) - $signed(DIFF_W'(nom_ohms) << CODE_FRAC_W);
    b_res_q8_nxt = a_fault_r ? '0 : a_scaled_r[SCALED_W-1:RES_SH];
    priority if (a_fault_r) begin
      b_status_nxt = a_status_r;
    end else if (res_bad) begin
      b_status_nxt = ST_RES_RANGE;
    end else if (nom_ohms == '0) begin
      b_status_nxt = ST_TEMP_RANGE;
    end else begin
      b_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_v_r) begin
      b_status_r <= b_status_nxt;
      b_clr_r    <= a_fault_r && a_clr_r;
      b_res_q8_r <= b_res_q8_nxt;
      b_diff_r   <= b_diff_nxt;
    end
  end

  // Stage C: numerator, denominator and temperature limits by constant products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en_c) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && b_v_r) begin
      c_status_r <= b_status_r;
      c_clr_r    <= b_clr_r;
      c_res_q8_r <= b_res_q8_r;
      c_num_r    <= NUM_W'(b_diff_r) * TEMP_NUM_K;
      c_den_r    <= DEN_W'(nom_ohms) * TEMP_DEN_K;
      c_lo_r     <= NUM_W'(nom_ohms) * TEMP_LO_K;
      c_hi_r     <= NUM_W'(nom_ohms) * TEMP_HI_K;
    end
  end

  // Stage D: temperature window, then magnitude and sign for the divider.
  always_comb begin
    temp_bad     = (c_num_r < -$signed(c_lo_r)) || (c_num_r > $signed(c_hi_r));
    d_status_nxt = (c_status_r == ST_OK && temp_bad) ? ST_TEMP_RANGE : c_status_r;
    num_abs      = c_num_r[NUM_W-1] ? NUM_W'(-c_num_r) : NUM_W'(c_num_r);
    d_req_nxt.meta.status = d_status_nxt;
    d_req_nxt.meta.clr    = c_clr_r;
    d_req_nxt.meta.res_q8 = c_res_q8_r;
    d_req_nxt.meta.neg    = c_num_r[NUM_W-1];
    d_req_nxt.dividend    = (d_status_nxt == ST_OK) ? num_abs[DVD_W-1:0] : '0;
    d_req_nxt.divisor     = c_den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en_d) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && c_v_r) begin
      d_req_r <= d_req_nxt;
    end
  end

  assign dn_valid = d_v_r;
  assign dn_req   = d_req_r;

endmodule

### rtl/core/rtdc_div.sv
// Pipelined restoring divider: one quotient bit per register stage, result
// fields carried alongside. Depends on rtdc_pkg.
module rtdc_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  rtdc_pkg::rtdc_div_req_t up_req,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output rtdc_pkg::rtdc_div_rsp_t dn_rsp
);
  import rtdc_pkg::*;

  logic [QUO_W:0]   en;

  // Stage inputs.
  logic             s_v    [QUO_W];
  logic [DVD_W-1:0] s_rem  [QUO_W];
  logic [DEN_W-1:0] s_den  [QUO_W];
  logic [QUO_W-1:0] s_quo  [QUO_W];
  rtdc_meta_t       s_meta [QUO_W];

  // Stage registers.
  logic             v_r    [QUO_W];
  logic [DVD_W-1:0] rem_r  [QUO_W];
  logic [DEN_W-1:0] den_r  [QUO_W];
  logic [QUO_W-1:0] quo_r  [QUO_W];
  rtdc_meta_t       meta_r [QUO_W];

  assign en[QUO_W] = dn_ready;

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int SH = QUO_W - 1 - j;
    logic [DVD_W-1:0] trial;
    logic             fits;

    // The first stage takes the request, the others their predecessor.
    if (j == 0) begin : g_head
      assign s_v[j]    = up_valid;
      assign s_rem[j]  = up_req.dividend;
      assign s_den[j]  = up_req.divisor;
      assign s_quo[j]  = '0;
      assign s_meta[j] = up_req.meta;
    end else begin : g_body
      assign s_v[j]    = v_r[j-1];
      assign s_rem[j]  = rem_r[j-1];
      assign s_den[j]  = den_r[j-1];
      assign s_quo[j]  = quo_r[j-1];
      assign s_meta[j] = meta_r[j-1];
    end

    assign en[j] = !v_r[j] || en[j+1];

    // Try the divisor at this bit weight and keep the difference if it fits.
    assign trial = DVD_W'(s_den[j]) << SH;
    assign fits  = s_rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= s_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j] && s_v[j]) begin
        rem_r[j]  <= fits ? (s_rem[j] - trial) : s_rem[j];
        quo_r[j]  <= s_quo[j] | (QUO_W'(fits) << SH);
        den_r[j]  <= s_den[j];
        meta_r[j] <= s_meta[j];
      end
    end
  end

  assign up_ready        = en[0];
  assign dn_valid        = v_r[QUO_W-1];
  assign dn_rsp.meta     = meta_r[QUO_W-1];
  assign dn_rsp.quotient = quo_r[QUO_W-1];

endmodule
